// ===== src/coarse_charge_stamp_peak_assert.svh =====
// assertion macros shared by the stamp modules
// each macro expects clk and rst_n in scope
`ifndef COARSE_CHARGE_STAMP_PEAK_ASSERT_SVH
`define COARSE_CHARGE_STAMP_PEAK_ASSERT_SVH

// same-cycle implication
`define CCSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ccsp: same-cycle check failed");

// next-cycle implication
`define CCSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ccsp: next-cycle check failed");

`endif

// ===== src/ccsp_pkg.sv =====
package ccsp_pkg;

  localparam int NUM_BINS    = 16;
  localparam int SAMPLE_BITS = 10;

  // port field widths
  localparam int IN_W  = 10;
  localparam int OUT_W = 10;
  localparam int IDX_W = 4;

  localparam int BIN_W = $clog2(NUM_BINS + 1);
  localparam int POS_W = $clog2(NUM_BINS);

  // slot codes of the three stamp words
  localparam logic [1:0] SLOT_BEFORE = 2'd0;
  localparam logic [1:0] SLOT_PEAK   = 2'd1;
  localparam logic [1:0] SLOT_AFTER  = 2'd2;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] prev;
    logic [SAMPLE_BITS-1:0] peak;
    logic [SAMPLE_BITS-1:0] after;
    logic [POS_W-1:0]       pos;
  } stamp_t;

  function automatic logic [SAMPLE_BITS-1:0] from_in_sample(input logic [IN_W-1:0] x);
    logic [15:0] w;
    w = 16'(x);
    return w[SAMPLE_BITS-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] to_out_sample(input logic [SAMPLE_BITS-1:0] x);
    logic [15:0] w;
    w = 16'(x);
    return w[OUT_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] to_out_index(input logic [POS_W-1:0] x);
    logic [7:0] w;
    w = 8'(x);
    return w[IDX_W-1:0];
  endfunction

endpackage

// ===== src/ccsp_in_if.sv =====
interface ccsp_in_if;
  logic                     valid;
  logic                     ready;
  logic [ccsp_pkg::IN_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== src/ccsp_out_if.sv =====
interface ccsp_out_if;
  logic                       valid;
  logic                       ready;
  logic [ccsp_pkg::OUT_W-1:0] stamp_sample;
  logic [ccsp_pkg::IDX_W-1:0] peak_index;
  logic                       range_flag;
  logic                       last_of_stamp;

  modport source (output valid, output stamp_sample, output peak_index,
                  output range_flag, output last_of_stamp, input ready);
  modport sink   (input valid, input stamp_sample, input peak_index,
                  input range_flag, input last_of_stamp, output ready);
endinterface

// ===== src/ccsp_tracker.sv =====
module ccsp_tracker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_fire,
  input  logic [ccsp_pkg::SAMPLE_BITS-1:0] sample,
  output logic                             trailing,
  output logic                             emit,
  output ccsp_pkg::stamp_t                 stamp
);

  `include "coarse_charge_stamp_peak_assert.svh"

  logic [ccsp_pkg::BIN_W-1:0]       bin_count_r, bin_count_nxt;
  logic                             await_after_r, await_after_nxt;
  logic [ccsp_pkg::SAMPLE_BITS-1:0] prior_sample_r, prior_sample_nxt;
  logic [ccsp_pkg::SAMPLE_BITS-1:0] peak_value_r, peak_value_nxt;
  logic [ccsp_pkg::SAMPLE_BITS-1:0] peak_before_r, peak_before_nxt;
  logic [ccsp_pkg::SAMPLE_BITS-1:0] peak_after_r, peak_after_nxt;
  logic [ccsp_pkg::POS_W-1:0]       peak_pos_r, peak_pos_nxt;
  logic                             candidate;

  assign trailing  = (bin_count_r == ccsp_pkg::BIN_W'(ccsp_pkg::NUM_BINS));
  assign candidate = !trailing && (sample > peak_value_r);

  always_comb begin
    bin_count_nxt    = bin_count_r;
    await_after_nxt  = await_after_r;
    prior_sample_nxt = prior_sample_r;
    peak_value_nxt   = peak_value_r;
    peak_before_nxt  = peak_before_r;
    peak_after_nxt   = peak_after_r;
    peak_pos_nxt     = peak_pos_r;
    if (in_fire) begin
      if (bin_count_r == '0) begin
        // bin 0 restarts the waveform
        peak_before_nxt = sample;
        peak_value_nxt  = '0;
        peak_pos_nxt    = ccsp_pkg::POS_W'(1);
        peak_after_nxt  = '0;
        await_after_nxt = 1'b0;
      end else begin
        if (await_after_r) begin
          peak_after_nxt  = sample;
          await_after_nxt = 1'b0;
        end
        if (candidate) begin
          peak_value_nxt  = sample;
          peak_before_nxt = prior_sample_r;
          peak_pos_nxt    = bin_count_r[ccsp_pkg::POS_W-1:0];
          await_after_nxt = 1'b1;
        end
      end
      prior_sample_nxt = sample;
      bin_count_nxt    = trailing ? '0 : bin_count_r + ccsp_pkg::BIN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r   <= '0;
      await_after_r <= 1'b0;
    end else begin
      bin_count_r   <= bin_count_nxt;
      await_after_r <= await_after_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prior_sample_r <= prior_sample_nxt;
    peak_value_r   <= peak_value_nxt;
    peak_before_r  <= peak_before_nxt;
    peak_after_r   <= peak_after_nxt;
    peak_pos_r     <= peak_pos_nxt;
  end

  // peak in the last candidate bin takes the trailing sample as its after word
  assign emit        = in_fire && trailing;
  assign stamp.prev  = peak_before_r;
  assign stamp.peak  = peak_value_r;
  assign stamp.after = await_after_r ? sample : peak_after_r;
  assign stamp.pos   = peak_pos_r;

  `CCSP_ASSERT_NEXT(a_wrap_after_trailing, emit, bin_count_r == '0)
  `CCSP_ASSERT_NEXT(a_bin_advance, in_fire && !trailing,
                    bin_count_r == $past(bin_count_r) + ccsp_pkg::BIN_W'(1))

endmodule

// ===== src/ccsp_serializer.sv =====
module ccsp_serializer (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  ccsp_pkg::stamp_t stamp,
  output logic             busy,
  ccsp_out_if.source       out_ch
);

  `include "coarse_charge_stamp_peak_assert.svh"

  logic                             busy_r, busy_nxt;
  logic [1:0]                       slot_r, slot_nxt;
  logic [ccsp_pkg::SAMPLE_BITS-1:0] before_r, peak_r, after_r;
  logic [ccsp_pkg::POS_W-1:0]       pos_r;
  logic                             range_r;
  logic                             drop;
  logic [ccsp_pkg::SAMPLE_BITS-1:0] keep_mask;
  logic [ccsp_pkg::SAMPLE_BITS-1:0] cur;
  logic                             out_fire;

  // any top bit set drops bit 0 of all three words
  assign drop = stamp.prev[ccsp_pkg::SAMPLE_BITS-1] | stamp.peak[ccsp_pkg::SAMPLE_BITS-1]
              | stamp.after[ccsp_pkg::SAMPLE_BITS-1];
  assign keep_mask = drop ? ~ccsp_pkg::SAMPLE_BITS'(1) : '1;
  assign out_fire  = out_ch.valid && out_ch.ready;

  always_comb begin
    busy_nxt = busy_r;
    slot_nxt = slot_r;
    if (load) begin
      busy_nxt = 1'b1;
      slot_nxt = ccsp_pkg::SLOT_BEFORE;
    end else if (out_fire) begin
      if (slot_r == ccsp_pkg::SLOT_AFTER) begin
        busy_nxt = 1'b0;
        slot_nxt = ccsp_pkg::SLOT_BEFORE;
      end else begin
        slot_nxt = slot_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      slot_r <= ccsp_pkg::SLOT_BEFORE;
    end else begin
      busy_r <= busy_nxt;
      slot_r <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      before_r <= stamp.prev & keep_mask;
      peak_r   <= stamp.peak & keep_mask;
      after_r  <= stamp.after & keep_mask;
      pos_r    <= stamp.pos;
      range_r  <= drop;
    end
  end

  always_comb begin
    case (slot_r)
      ccsp_pkg::SLOT_BEFORE: cur = before_r;
      ccsp_pkg::SLOT_PEAK:   cur = peak_r;
      ccsp_pkg::SLOT_AFTER:  cur = after_r;
      default:               cur = after_r;
    endcase
  end

  assign busy                 = busy_r;
  assign out_ch.valid         = busy_r;
  assign out_ch.stamp_sample  = ccsp_pkg::to_out_sample(cur);
  assign out_ch.peak_index    = ccsp_pkg::to_out_index(pos_r);
  assign out_ch.range_flag    = range_r;
  assign out_ch.last_of_stamp = (slot_r == ccsp_pkg::SLOT_AFTER);

  `CCSP_ASSERT_NOW(a_no_load_while_busy, load, !busy_r)
  `CCSP_ASSERT_NOW(a_range_clears_lsb, busy_r && range_r, cur[0] == 1'b0)
  `CCSP_ASSERT_NEXT(a_slot_holds_on_stall, busy_r && !out_ch.ready,
                    busy_r && $stable(slot_r))
  `CCSP_ASSERT_NEXT(a_drain_ends, out_fire && (slot_r == ccsp_pkg::SLOT_AFTER) && !load,
                    !busy_r)

endmodule

// ===== src/coarse_charge_stamp_peak.sv =====
// channel   dir  fields                                                 words per waveform
// in_ch     in   sample[9:0]                                            NUM_BINS+1
// out_ch    out  stamp_sample[9:0] peak_index[3:0] range_flag last_of_stamp   3
//
// one sample word per cycle unless stalled: the peak compare and state update sit
// between the input port and the tracker registers, one compare per sample
// the stamp sits in a three-word result register and drains one word per cycle
// while out_ch.ready is high, as the next waveform streams in
// only the trailing bin waits on a stall: it is held while the previous stamp
// still has words left, all other bins are always taken
// rst_n is synchronous, active low; it clears the bin counter and the drain state
module coarse_charge_stamp_peak (
  input  logic        clk,
  input  logic        rst_n,
  ccsp_in_if.sink     in_ch,
  ccsp_out_if.source  out_ch
);

  logic                             in_fire;
  logic                             trailing;
  logic                             emit;
  logic                             busy;
  logic [ccsp_pkg::SAMPLE_BITS-1:0] sample;
  ccsp_pkg::stamp_t                 stamp;

  // trailing bin would load a new stamp, so it waits for the result register
  assign in_ch.ready = !(trailing && busy);
  assign in_fire     = in_ch.valid && in_ch.ready;
  // only the low SAMPLE_BITS bits of a sample word count
  assign sample      = ccsp_pkg::from_in_sample(in_ch.sample);

  // running peak search over bins 1 to NUM_BINS-1
  ccsp_tracker u_tracker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .sample   (sample),
    .trailing (trailing),
    .emit     (emit),
    .stamp    (stamp)
  );

  // range fix-up and three-word drain
  ccsp_serializer u_serializer (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (emit),
    .stamp  (stamp),
    .busy   (busy),
    .out_ch (out_ch)
  );

endmodule
